FILE: sv/cst_pkg.sv
package cst_pkg;

  // Field widths of the request and response words.
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned SEM_INDEX_W  = 4;
  localparam int unsigned PROCESS_ID_W = 8;
  localparam int unsigned INIT_VALUE_W = 16;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned NUM_SEMS_DEF    = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned PID_BITS_DEF    = 8;

  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_INIT    = 2'd0,
    ACT_WAIT    = 2'd1,
    ACT_POST    = 2'd2,
    ACT_DESTROY = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_READY    = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

endpackage

FILE: sv/cst_if.sv
interface cst_in_if;
  import cst_pkg::*;

  logic                           valid;
  logic                           ready;
  logic        [ACTION_W-1:0]     action;
  logic        [SEM_INDEX_W-1:0]  sem_index;
  logic        [PROCESS_ID_W-1:0] process_id;
  logic signed [INIT_VALUE_W-1:0] init_value;

  modport source (output valid, action, sem_index, process_id, init_value, input ready);
  modport sink   (input valid, action, sem_index, process_id, init_value, output ready);
endinterface

interface cst_out_if;
  import cst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PROCESS_ID_W-1:0] result_process;
  logic [STATUS_W-1:0]     result_status;
  logic                    last;

  modport source (output valid, result_process, result_status, last, input ready);
  modport sink   (input valid, result_process, result_status, last, output ready);
endinterface

FILE: sv/cst_ram.sv
module cst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read word holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/counting_semaphore_table.sv
// The request is registered in the request stage, and its result word in the result stage.
// Throughput: one request per cycle while the output is not stalled; a post that releases a
// waiter holds the output for two words, so the result register holds back the request after it.
// Reset: the pipeline and the per-entry valid flags clear at once; there is no clearing
// pass, and the waiter storage stays undefined until written.
module counting_semaphore_table #(
  parameter int unsigned NUM_SEMS    = cst_pkg::NUM_SEMS_DEF,
  parameter int unsigned QUEUE_DEPTH = cst_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PID_BITS    = cst_pkg::PID_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cst_in_if.sink    sem_req,
  cst_out_if.source sem_rsp
);
  import cst_pkg::*;

  localparam int unsigned SIDX_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int unsigned QH_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QF_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned WDEPTH  = NUM_SEMS * QUEUE_DEPTH;
  localparam int unsigned WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int unsigned ST_W    = COUNT_W + QH_W + QF_W;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic [QH_W-1:0]           head;
    logic [QF_W-1:0]           fill;
  } sem_state_t;

  // Request stage.
  logic                           x1_valid_q;
  action_e                        x1_action_q;
  logic        [SEM_INDEX_W-1:0]  x1_idx_q;
  logic        [PID_BITS-1:0]     x1_pid_q;
  logic signed [INIT_VALUE_W-1:0] x1_ival_q;
  logic                           byp_hit_q;
  sem_state_t                     byp_state_q;

  // Result stage.
  logic                x2_valid_q;
  logic [PID_BITS-1:0] x2_pid_q;
  status_e             x2_status_q;
  logic                x2_waiter_q;

  logic [NUM_SEMS-1:0] valid_q;

  logic              in_acc;
  logic              x1_adv;
  logic              x2_done;
  logic              out_hs;
  logic [SIDX_W-1:0] x1_sidx;
  logic [SIDX_W-1:0] in_sidx;
  logic              in_range;
  logic              entry_ok;
  logic [ST_W-1:0]   st_rdata;
  sem_state_t        cur;
  sem_state_t        st_wdata;
  logic              st_we;
  logic [PID_BITS-1:0] wt_rdata;
  logic              wt_we;
  logic              wt_re;
  logic [WADDR_W-1:0] wt_addr;
  logic [WADDR_W-1:0] wt_base;
  logic [QF_W:0]     tail_sum;
  logic [QH_W-1:0]   tail_slot;
  logic [QH_W-1:0]   head_next;
  logic signed [COUNT_W-1:0] count_dec;
  logic              q_full;
  logic              valid_set;
  logic              valid_clr;
  logic              has_waiter;
  status_e           status;

  assign in_acc  = sem_req.valid & sem_req.ready;
  assign out_hs  = sem_rsp.valid & sem_rsp.ready;
  assign x2_done = out_hs & ~x2_waiter_q;
  assign x1_adv  = x1_valid_q & (~x2_valid_q | x2_done);
  assign sem_req.ready = ~x1_valid_q | x1_adv;

  assign x1_sidx  = SIDX_W'(x1_idx_q);
  assign in_sidx  = SIDX_W'(sem_req.sem_index);
  assign in_range = (32'(x1_idx_q) < NUM_SEMS);
  assign entry_ok = in_range && valid_q[x1_sidx];

  // The state word written by the request leaving this stage is forwarded to the next one.
  assign cur = byp_hit_q ? byp_state_q : sem_state_t'(st_rdata);

  assign wt_base   = WADDR_W'(32'(x1_sidx) * QUEUE_DEPTH);
  assign tail_sum  = (QF_W+1)'(cur.head) + (QF_W+1)'(cur.fill);
  assign tail_slot = (32'(tail_sum) >= QUEUE_DEPTH) ? QH_W'(32'(tail_sum) - QUEUE_DEPTH)
                                                    : QH_W'(tail_sum);
  assign head_next = (32'(cur.head) == QUEUE_DEPTH - 1) ? '0 : QH_W'(cur.head + 1'b1);
  assign count_dec = (cur.count == COUNT_MIN) ? COUNT_MIN : cur.count - 16'sd1;
  assign q_full    = (32'(cur.fill) >= QUEUE_DEPTH);

  always_comb begin
    st_we      = 1'b0;
    st_wdata   = cur;
    wt_we      = 1'b0;
    wt_re      = 1'b0;
    wt_addr    = wt_base;
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    has_waiter = 1'b0;
    status     = ST_REJECTED;
    case (x1_action_q)
      ACT_INIT: begin
        if (in_range) begin
          status         = ST_READY;
          st_we          = 1'b1;
          st_wdata.count = COUNT_W'(x1_ival_q);
          st_wdata.head  = '0;
          st_wdata.fill  = '0;
          valid_set      = 1'b1;
        end
      end
      ACT_WAIT: begin
        if (entry_ok) begin
          if (count_dec[COUNT_W-1]) begin
            if (!q_full) begin
              status         = ST_BLOCKED;
              wt_we          = 1'b1;
              wt_addr        = wt_base + WADDR_W'(tail_slot);
              st_we          = 1'b1;
              st_wdata.count = count_dec;
              st_wdata.fill  = cur.fill + 1'b1;
            end
          end else begin
            status         = ST_READY;
            st_we          = 1'b1;
            st_wdata.count = count_dec;
          end
        end
      end
      ACT_POST: begin
        if (entry_ok) begin
          status = ST_READY;
          st_we  = 1'b1;
          if (cur.count != COUNT_MAX) begin
            st_wdata.count = cur.count + 16'sd1;
          end
          if (cur.fill != '0) begin
            wt_re         = 1'b1;
            wt_addr       = wt_base + WADDR_W'(cur.head);
            st_wdata.head = head_next;
            st_wdata.fill = cur.fill - 1'b1;
            has_waiter    = 1'b1;
          end
        end
      end
      ACT_DESTROY: begin
        // The queue contents are ignored until the next init rewrites the state word.
        if (entry_ok) begin
          status    = ST_READY;
          valid_clr = 1'b1;
        end
      end
      default: begin
        status = ST_REJECTED;
      end
    endcase
  end

  cst_ram #(
    .WIDTH (ST_W),
    .DEPTH (NUM_SEMS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (x1_adv & st_we),
    .waddr_i (x1_sidx),
    .wdata_i (st_wdata),
    .re_i    (in_acc),
    .raddr_i (in_sidx),
    .rdata_o (st_rdata)
  );

  cst_ram #(
    .WIDTH (PID_BITS),
    .DEPTH (WDEPTH)
  ) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (x1_adv & wt_we),
    .waddr_i (wt_addr),
    .wdata_i (x1_pid_q),
    .re_i    (x1_adv & wt_re),
    .raddr_i (wt_addr),
    .rdata_o (wt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
      x2_valid_q <= 1'b0;
      x2_waiter_q <= 1'b0;
      valid_q    <= '0;
    end else begin
      if (in_acc) begin
        x1_valid_q <= 1'b1;
        byp_hit_q  <= x1_adv & st_we & (x1_sidx == in_sidx);
      end else if (x1_adv) begin
        x1_valid_q <= 1'b0;
      end

      if (x1_adv) begin
        x2_valid_q  <= 1'b1;
        x2_waiter_q <= has_waiter;
        if (valid_set) begin
          valid_q[x1_sidx] <= 1'b1;
        end
        if (valid_clr) begin
          valid_q[x1_sidx] <= 1'b0;
        end
      end else if (x2_done) begin
        x2_valid_q <= 1'b0;
      end else if (out_hs) begin
        // The released waiter went out; the caller's word follows.
        x2_waiter_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x1_action_q <= action_e'(sem_req.action);
      x1_idx_q    <= sem_req.sem_index;
      x1_pid_q    <= PID_BITS'(sem_req.process_id);
      x1_ival_q   <= sem_req.init_value;
      byp_state_q <= st_wdata;
    end
    if (x1_adv) begin
      x2_pid_q    <= x1_pid_q;
      x2_status_q <= status;
    end
  end

  assign sem_rsp.valid          = x2_valid_q;
  assign sem_rsp.result_process = x2_waiter_q ? PROCESS_ID_W'(wt_rdata)
                                              : PROCESS_ID_W'(x2_pid_q);
  assign sem_rsp.result_status  = x2_waiter_q ? ST_READY : x2_status_q;
  assign sem_rsp.last           = ~x2_waiter_q;

endmodule

FILE: sv/cst_checker.sv
module cst_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [cst_pkg::PROCESS_ID_W-1:0] out_process_i,
  input logic [cst_pkg::STATUS_W-1:0]     out_status_i,
  input logic                             out_last_i
);
  import cst_pkg::*;

  // A stalled result word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_process_i)
      && $stable(out_status_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  // Only a released waiter precedes another word, and it is always reported ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_status_i == ST_READY)
    else $error("non-final result word is not a ready waiter");

  // The caller's word follows a released waiter at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
      out_valid_i && out_last_i && out_status_i == ST_READY)
    else $error("caller word did not follow the released waiter");

endmodule

bind counting_semaphore_table cst_checker u_cst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (sem_rsp.valid),
  .out_ready_i   (sem_rsp.ready),
  .out_process_i (sem_rsp.result_process),
  .out_status_i  (sem_rsp.result_status),
  .out_last_i    (sem_rsp.last)
);
